// ===== rtl/dedup_move_queue_defines.svh =====
// assertion macros used by rtl/dedup_move_queue.sv
`ifndef DEDUP_MOVE_QUEUE_DEFINES_SVH
`define DEDUP_MOVE_QUEUE_DEFINES_SVH

`ifndef ASSERT_OFF
// checked only while out of reset
`define DMQ_ASSERT(name, prop, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
// checked on every edge, reset included
`define DMQ_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge i_clk) (prop)) else $error(msg);
`else
`define DMQ_ASSERT(name, prop, msg)
`define DMQ_ASSERT_ALWAYS(name, prop, msg)
`endif

`endif

// ===== rtl/dmq_pkg.sv =====
`timescale 1ns / 1ps

package dmq_pkg;

    localparam int DEF_CAPACITY   = 128;
    localparam int DEF_COORD_BITS = 3;
    localparam int SLOT_W         = 7;
    localparam int CNT_W          = 8;
    localparam int OP_W           = 3;
    localparam int STATUS_W       = 2;

    localparam logic [OP_W-1:0] OP_PUSH        = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_UNIQUE = 3'd1;
    localparam logic [OP_W-1:0] OP_POP         = 3'd2;
    localparam logic [OP_W-1:0] OP_READ_AT     = 3'd3;
    localparam logic [OP_W-1:0] OP_FIND        = 3'd4;
    localparam logic [OP_W-1:0] OP_CLEAR       = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_FETCH  = 4'b0100,
        S_COMMIT = 4'b1000
    } t_state;

endpackage

// ===== rtl/dedup_move_queue.sv =====
`timescale 1ns / 1ps
// channel  | direction | handshake                 | payload
// ---------+-----------+---------------------------+-------------------------------------
// input    | in        | i_in_valid / o_in_stall   | operation, move, slot_index
// output   | out       | o_out_valid / i_out_stall | move, hit, live_count, unique_adds, status
//
// push and clear commit directly; pop and read_at first take one registered store read.
// push_unique and find scan before commit: one shared comparator walks the
// live region one entry a cycle through the store's single read port, stopping at a match.
// o_in_stall is high from acceptance until the result is loaded into the output register.
// a held result on the output waits in the commit step, state unchanged until it goes.
// synchronous active-low reset clears pointers, counter and handshake state.

`include "dedup_move_queue_defines.svh"

module dedup_move_queue
    import dmq_pkg::*;
#(
    parameter int CAPACITY   = DEF_CAPACITY,
    parameter int COORD_BITS = DEF_COORD_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [OP_W-1:0]       i_operation,
    input  logic [COORD_BITS-1:0] i_src_col,
    input  logic [COORD_BITS-1:0] i_src_row,
    input  logic [COORD_BITS-1:0] i_dst_col,
    input  logic [COORD_BITS-1:0] i_dst_row,
    input  logic [SLOT_W-1:0]     i_slot_index,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [COORD_BITS-1:0] o_out_src_col,
    output logic [COORD_BITS-1:0] o_out_src_row,
    output logic [COORD_BITS-1:0] o_out_dst_col,
    output logic [COORD_BITS-1:0] o_out_dst_row,
    output logic                  o_hit,
    output logic [CNT_W-1:0]      o_live_count,
    output logic [CNT_W-1:0]      o_unique_adds,
    output logic [STATUS_W-1:0]   o_status
);

    localparam int MOVE_W = 4 * COORD_BITS;
    localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int PTR_W  = $clog2(CAPACITY + 1);
    localparam int CMP_W  = (PTR_W > SLOT_W) ? PTR_W : SLOT_W;
    localparam logic [PTR_W-1:0] CAP_PTR = PTR_W'(CAPACITY);

    logic [MOVE_W-1:0] r_mem [CAPACITY];
    logic [MOVE_W-1:0] r_rd_data;
    logic [ADDR_W-1:0] rd_addr;
    logic              mem_we;

    t_state            r_state, n_state;
    logic [OP_W-1:0]   r_op;
    logic [MOVE_W-1:0] r_move;
    logic [SLOT_W-1:0] r_slot;
    logic [PTR_W-1:0]  r_head, n_head;
    logic [PTR_W-1:0]  r_tail, n_tail;
    logic [PTR_W-1:0]  r_uniq, n_uniq;
    logic [PTR_W-1:0]  r_scan_ptr;
    logic              r_rd_pend;
    logic              r_hit;
    logic              r_out_valid;

    logic [MOVE_W-1:0]   res_move;
    logic                res_hit;
    logic [STATUS_W-1:0] res_status;
    logic [PTR_W-1:0]    live_diff;

    logic in_acc, out_free, commit, match, scan_more, full;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign commit      = (r_state == S_COMMIT) && out_free;
    assign match       = r_rd_pend && (r_rd_data == r_move);
    assign scan_more   = (r_scan_ptr < r_tail);
    assign full        = (r_tail >= CAP_PTR);

    // one read port: scan walks the live region, otherwise head or slot index
    always_comb begin
        if (r_state == S_SCAN) begin
            rd_addr = r_scan_ptr[ADDR_W-1:0];
        end else if (r_op == OP_POP) begin
            rd_addr = r_head[ADDR_W-1:0];
        end else begin
            rd_addr = ADDR_W'(r_slot);
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_tail[ADDR_W-1:0]] <= r_move;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    case (i_operation)
                        OP_PUSH_UNIQUE, OP_FIND: n_state = S_SCAN;
                        OP_POP, OP_READ_AT:      n_state = S_FETCH;
                        default:                 n_state = S_COMMIT;
                    endcase
                end
            end
            S_SCAN: begin
                if (match || !scan_more) begin
                    n_state = S_COMMIT;
                end
            end
            S_FETCH:  n_state = S_COMMIT;
            S_COMMIT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_head     = r_head;
        n_tail     = r_tail;
        n_uniq     = r_uniq;
        mem_we     = 1'b0;
        res_move   = '0;
        res_hit    = 1'b0;
        res_status = ST_OK;
        case (r_op)
            OP_PUSH: begin
                if (full) begin
                    res_status = ST_FULL;
                end else begin
                    mem_we = commit;
                    n_tail = r_tail + 1'b1;
                end
            end
            OP_PUSH_UNIQUE: begin
                if (r_hit) begin
                    res_hit = 1'b1;
                end else if (full) begin
                    res_status = ST_FULL;
                end else begin
                    mem_we = commit;
                    n_tail = r_tail + 1'b1;
                    n_uniq = r_uniq + 1'b1;
                end
            end
            OP_POP: begin
                if (r_head >= r_tail) begin
                    res_status = ST_EMPTY;
                end else begin
                    res_move = r_rd_data;
                    n_head   = r_head + 1'b1;
                end
            end
            OP_READ_AT: begin
                if (CMP_W'(r_slot) >= CMP_W'(r_tail)) begin
                    res_status = ST_RANGE;
                end else begin
                    res_move = r_rd_data;
                end
            end
            OP_FIND:  res_hit = r_hit;
            OP_CLEAR: begin
                n_head = '0;
                n_tail = '0;
                n_uniq = '0;
            end
            default: ;
        endcase
    end

    assign live_diff = n_tail - n_head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_uniq      <= '0;
            r_out_valid <= 1'b0;
            r_rd_pend   <= 1'b0;
            r_hit       <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_acc) begin
                r_rd_pend <= 1'b0;
                r_hit     <= 1'b0;
            end else if (r_state == S_SCAN) begin
                r_rd_pend <= scan_more && !match;
                if (match) begin
                    r_hit <= 1'b1;
                end
            end
            if (commit) begin
                r_head      <= n_head;
                r_tail      <= n_tail;
                r_uniq      <= n_uniq;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op       <= i_operation;
            r_move     <= {i_src_col, i_src_row, i_dst_col, i_dst_row};
            r_slot     <= i_slot_index;
            r_scan_ptr <= r_head;
        end else if ((r_state == S_SCAN) && scan_more) begin
            r_scan_ptr <= r_scan_ptr + 1'b1;
        end
        if (commit) begin
            {o_out_src_col, o_out_src_row, o_out_dst_col, o_out_dst_row} <= res_move;
            o_hit         <= res_hit;
            o_status      <= res_status;
            o_live_count  <= (32'(live_diff) > 32'd255) ? 8'd255 : CNT_W'(live_diff);
            o_unique_adds <= (32'(n_uniq) > 32'd255) ? 8'd255 : CNT_W'(n_uniq);
        end
    end

    `DMQ_ASSERT(a_head_le_tail, r_head <= r_tail, "head pointer passed tail pointer")
    `DMQ_ASSERT(a_tail_le_cap, r_tail <= CAP_PTR, "tail pointer beyond capacity")
    `DMQ_ASSERT(a_uniq_le_tail, r_uniq <= r_tail, "unique count exceeds appended entries")
    `DMQ_ASSERT(a_scan_ge_head, (r_state == S_SCAN) |-> r_scan_ptr >= r_head, "scan below head")
    `DMQ_ASSERT(a_scan_le_tail, (r_state == S_SCAN) |-> r_scan_ptr <= r_tail, "scan past tail")
    `DMQ_ASSERT(a_accept_busy, in_acc |=> (r_state != S_IDLE), "accepted item did not start")

endmodule
